FILE: sv/pts_pkg.sv
package pts_pkg;

    localparam int MAX_PIXELS  = 4096;
    localparam int MAX_FRAMES  = 256;
    localparam int PIX_BITS    = 12;
    localparam int PCNT_BITS   = 13;
    localparam int FCNT_BITS   = 9;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SUM_BITS    = 24;
    localparam int SQ_BITS     = 40;
    localparam int PROD_BITS   = 56;
    localparam int NUM_BITS    = PROD_BITS + FRAC_BITS;
    localparam int QUO_BITS    = 49;
    localparam int DEN_BITS    = 24;
    localparam int CFG_BITS    = 13;
    localparam int CIDX_BITS   = 2;

    localparam logic [CIDX_BITS-1:0] REG_MODE   = 2'd0;
    localparam logic [CIDX_BITS-1:0] REG_FRAMES = 2'd1;
    localparam logic [CIDX_BITS-1:0] REG_PIXELS = 2'd2;

    typedef enum logic [1:0] {
        MODE_MEAN = 2'd0,
        MODE_VAR  = 2'd1,
        MODE_ACOV = 2'd2,
        MODE_INT  = 2'd3
    } stat_mode_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] pix;
        logic                err;
        logic                last;
        logic                neg;
    } tag_t;

endpackage

FILE: sv/pixel_temporal_statistics_top.sv
// Per-pixel temporal statistics. Samples arrive frame-major, raster order within a frame;
// during the last frame of a stack every beat yields one result: mean, variance or lag-1
// autocovariance of that pixel, signed fixed point with 16 fraction bits, rounded down.
// One beat is accepted per cycle unless the output stalls; a result passes four arithmetic
// stages, a divider input register plus 49 stages at one quotient bit per stage, and an
// output register. The per-pixel accumulators live in one 4096-entry memory updated by a
// read-modify-write with a one-entry bypass, so a one-pixel frame also runs at full rate.
// No clearing pass: frame 0 overwrites each entry. Any write to the mode, frames or pixels
// register restarts the stack; write registers only while the block is empty.
module pixel_temporal_statistics_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [pts_pkg::CIDX_BITS-1:0]         cfg_index,
    input  logic [pts_pkg::CFG_BITS-1:0]          cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [pts_pkg::SAMPLE_BITS-1:0]       s_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [pts_pkg::PIX_BITS-1:0]          m_pixel_index,
    output logic signed [pts_pkg::QUO_BITS-1:0]   m_stat_value,
    output logic                                  m_error_flag,
    output logic                                  m_last_result
);

    localparam int PB  = pts_pkg::PIX_BITS;
    localparam int SB  = pts_pkg::SAMPLE_BITS;
    localparam int UB  = pts_pkg::SUM_BITS;
    localparam int QB  = pts_pkg::SQ_BITS;
    localparam int AB  = pts_pkg::PROD_BITS;
    localparam int FB  = pts_pkg::FCNT_BITS;
    localparam int CB  = pts_pkg::PCNT_BITS;
    localparam int OB  = pts_pkg::QUO_BITS;
    localparam int DB  = pts_pkg::DEN_BITS;
    localparam int MW  = UB + 2 * QB + SB;

    // configuration
    pts_pkg::stat_mode_t  mode_reg;
    logic [FB-1:0]        frames_reg;
    logic [CB-1:0]        pixels_reg;
    logic [FB-1:0]        nf;
    logic [CB-1:0]        np;
    logic [FB-2:0]        nm1;
    logic [2*FB-2:0]      nn_reg;
    logic [DB-1:0]        nnm_reg;
    logic [DB-1:0]        den;

    logic                 adv;
    logic                 accept;

    // input counters
    logic [PB-1:0]        pcnt_reg, pcnt_next;
    logic [FB-2:0]        fcnt_reg, fcnt_next;
    logic                 last_frame, last_pixel;

    // stage 1
    logic                 v1_reg, first1_reg, lf1_reg, lp1_reg;
    logic [PB-1:0]        p1_reg;
    logic [SB-1:0]        smp1_reg;
    logic [2*SB-1:0]      ssq1_reg;
    logic [MW-1:0]        mem [0:pts_pkg::MAX_PIXELS-1];
    logic [MW-1:0]        rd_reg;
    logic [MW-1:0]        fwd_data_reg;
    logic [PB-1:0]        fwd_addr_reg;
    logic                 fwd_valid_reg;
    logic [MW-1:0]        cur;
    logic [UB-1:0]        cur_sum, new_sum;
    logic [QB-1:0]        cur_sq, new_sq, cur_lag, new_lag;
    logic [SB-1:0]        cur_prev;
    logic [MW-1:0]        new_word;

    // stages 2..4
    logic                 v2_reg, lp2_reg;
    logic [PB-1:0]        p2_reg;
    logic [UB-1:0]        sum2_reg;
    logic [QB-1:0]        sq2_reg, lag2_reg;
    logic                 v3_reg, lp3_reg;
    logic [PB-1:0]        p3_reg;
    logic [UB-1:0]        sum3_reg;
    logic [QB+FB-1:0]     nsq3_reg, lagn3_reg;
    logic [2*UB-1:0]      ssum3_reg;
    logic                 v4_reg, lp4_reg, err4_reg;
    logic [PB-1:0]        p4_reg;
    logic [AB-1:0]        a4_reg, b4_reg;
    logic [AB-1:0]        a4_next, b4_next;
    logic [AB-1:0]        mag;
    pts_pkg::tag_t        dtag;

    // divider and output
    logic                 dv;
    logic [OB-1:0]        quo;
    logic                 rem_nz;
    pts_pkg::tag_t        otag;
    logic [OB-1:0]        value_next;

    always_comb begin
        if (frames_reg == '0) begin
            nf = FB'(1);
        end else if (frames_reg > FB'(pts_pkg::MAX_FRAMES)) begin
            nf = FB'(pts_pkg::MAX_FRAMES);
        end else begin
            nf = frames_reg;
        end
        if (pixels_reg == '0) begin
            np = CB'(1);
        end else if (pixels_reg > CB'(pts_pkg::MAX_PIXELS)) begin
            np = CB'(pts_pkg::MAX_PIXELS);
        end else begin
            np = pixels_reg;
        end
        nm1 = (FB - 1)'(nf - FB'(1));
    end

    always_comb begin
        case (mode_reg)
            pts_pkg::MODE_VAR:  den = DB'(nn_reg);
            pts_pkg::MODE_ACOV: den = nnm_reg;
            default:            den = DB'(nf);
        endcase
    end

    assign adv    = !m_valid || m_ready;
    assign s_ready = adv;
    assign accept = s_valid && adv;

    assign last_frame = ({1'b0, fcnt_reg} + FB'(1)) == nf;
    assign last_pixel = ({1'b0, pcnt_reg} + CB'(1)) == np;

    always_comb begin
        pcnt_next = pcnt_reg;
        fcnt_next = fcnt_reg;
        if (accept) begin
            if (last_pixel) begin
                pcnt_next = '0;
                fcnt_next = last_frame ? '0 : fcnt_reg + 1'b1;
            end else begin
                pcnt_next = pcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= pts_pkg::MODE_MEAN;
            frames_reg <= FB'(1);
            pixels_reg <= CB'(pts_pkg::MAX_PIXELS);
            pcnt_reg   <= '0;
            fcnt_reg   <= '0;
        end else if (cfg_we && (cfg_index == pts_pkg::REG_MODE ||
                                cfg_index == pts_pkg::REG_FRAMES ||
                                cfg_index == pts_pkg::REG_PIXELS)) begin
            case (cfg_index)
                pts_pkg::REG_MODE:   mode_reg   <= pts_pkg::stat_mode_t'(cfg_wdata[1:0]);
                pts_pkg::REG_FRAMES: frames_reg <= cfg_wdata[FB-1:0];
                pts_pkg::REG_PIXELS: pixels_reg <= cfg_wdata;
                default:             mode_reg   <= mode_reg;
            endcase
            pcnt_reg <= '0;
            fcnt_reg <= '0;
        end else begin
            pcnt_reg <= pcnt_next;
            fcnt_reg <= fcnt_next;
        end
    end

    // divisor constants are registered from the frame count: nn_reg first, then nnm_reg from nn_reg
    always_ff @(posedge aclk) begin
        nn_reg  <= (2 * FB - 1)'(nf) * (2 * FB - 1)'(nf);
        nnm_reg <= DB'(nn_reg) * DB'(nm1);
    end

    // stage 1: memory read and square
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= accept;
            fwd_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_reg       <= mem[pcnt_reg];
            p1_reg       <= pcnt_reg;
            first1_reg   <= (fcnt_reg == '0);
            lf1_reg      <= last_frame;
            lp1_reg      <= last_pixel;
            smp1_reg     <= s_sample;
            ssq1_reg     <= (2 * SB)'(s_sample) * (2 * SB)'(s_sample);
            fwd_data_reg <= new_word;
            fwd_addr_reg <= p1_reg;
            if (v1_reg) begin
                mem[p1_reg] <= new_word;
            end
        end
    end

    // bypass the entry written on the same edge as this read
    always_comb begin
        cur      = (fwd_valid_reg && fwd_addr_reg == p1_reg) ? fwd_data_reg : rd_reg;
        cur_sum  = cur[MW-1 -: UB];
        cur_sq   = cur[MW-UB-1 -: QB];
        cur_lag  = cur[SB+QB-1 -: QB];
        cur_prev = cur[SB-1:0];
        if (first1_reg) begin
            new_sum = UB'(smp1_reg);
            new_sq  = QB'(ssq1_reg);
            new_lag = '0;
        end else begin
            new_sum = cur_sum + UB'(smp1_reg);
            new_sq  = cur_sq + QB'(ssq1_reg);
            new_lag = cur_lag + QB'((2 * SB)'(cur_prev) * (2 * SB)'(smp1_reg));
        end
        new_word = {new_sum, new_sq, new_lag, smp1_reg};
    end

    // stage 2..4: products and operand selection
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg && lf1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb begin
        case (mode_reg)
            pts_pkg::MODE_VAR: begin
                a4_next = AB'(nsq3_reg);
                b4_next = AB'(ssum3_reg);
            end
            pts_pkg::MODE_ACOV: begin
                a4_next = AB'(lagn3_reg) * AB'(nf);
                b4_next = AB'(ssum3_reg) * AB'(nm1);
            end
            default: begin
                a4_next = AB'(sum3_reg);
                b4_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_reg    <= p1_reg;
            lp2_reg   <= lp1_reg;
            sum2_reg  <= new_sum;
            sq2_reg   <= new_sq;
            lag2_reg  <= new_lag;
            p3_reg    <= p2_reg;
            lp3_reg   <= lp2_reg;
            sum3_reg  <= sum2_reg;
            nsq3_reg  <= (QB + FB)'(sq2_reg) * (QB + FB)'(nf);
            lagn3_reg <= (QB + FB)'(lag2_reg) * (QB + FB)'(nf);
            ssum3_reg <= (2 * UB)'(sum2_reg) * (2 * UB)'(sum2_reg);
            p4_reg    <= p3_reg;
            lp4_reg   <= lp3_reg;
            a4_reg    <= a4_next;
            b4_reg    <= b4_next;
            err4_reg  <= (mode_reg == pts_pkg::MODE_ACOV) && (nf == FB'(1));
        end
    end

    always_comb begin
        if (err4_reg) begin
            mag = '0;
        end else if (a4_reg >= b4_reg) begin
            mag = a4_reg - b4_reg;
        end else begin
            mag = b4_reg - a4_reg;
        end
        dtag.pix  = p4_reg;
        dtag.err  = err4_reg;
        dtag.last = lp4_reg;
        dtag.neg  = !err4_reg && (a4_reg < b4_reg);
    end

    pts_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v4_reg),
        .num       ({mag, pts_pkg::FRAC_BITS'(0)}),
        .den       (den),
        .in_tag    (dtag),
        .out_valid (dv),
        .quo       (quo),
        .rem_nz    (rem_nz),
        .out_tag   (otag)
    );

    // floor for negatives: -(q + 1) when a remainder is left; error beats divide by zero
    assign value_next = otag.err ? '0 :
                        (otag.neg ? (OB'(0) - (quo + OB'(rem_nz))) : quo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pixel_index <= otag.pix;
            m_stat_value  <= value_next;
            m_error_flag  <= otag.err;
            m_last_result <= otag.last;
        end
    end

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_flag |-> m_stat_value == '0)
        else $error("error result carries a nonzero value");

    a_err_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_flag |-> mode_reg == pts_pkg::MODE_ACOV && nf == FB'(1))
        else $error("error flag outside single-frame autocovariance");

    a_pix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pcnt_reg} < np)
        else $error("pixel counter beyond frame size");

    a_res_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && adv && !lf1_reg |=> !v2_reg)
        else $error("result issued outside the last frame");

endmodule

FILE: sv/pts_div.sv
module pts_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [pts_pkg::NUM_BITS-1:0]  num,
    input  logic [pts_pkg::DEN_BITS-1:0]  den,
    input  pts_pkg::tag_t                 in_tag,
    output logic                          out_valid,
    output logic [pts_pkg::QUO_BITS-1:0]  quo,
    output logic                          rem_nz,
    output pts_pkg::tag_t                 out_tag
);

    localparam int STEPS = pts_pkg::QUO_BITS;
    localparam int DB    = pts_pkg::DEN_BITS;

    logic                          v_reg   [0:STEPS];
    logic [DB-1:0]                 rem_reg [0:STEPS];
    logic [STEPS-1:0]              nq_reg  [0:STEPS];
    pts_pkg::tag_t                 tag_reg [0:STEPS];

    logic [DB:0]                   trial    [0:STEPS-1];
    logic [DB-1:0]                 rem_next [0:STEPS-1];
    logic [STEPS-1:0]              nq_next  [0:STEPS-1];

    // one quotient bit per stage; upper numerator bits start as remainder
    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            trial[k] = {rem_reg[k], nq_reg[k][STEPS-1]};
            if (trial[k] >= {1'b0, den}) begin
                rem_next[k] = DB'(trial[k] - {1'b0, den});
                nq_next[k]  = {nq_reg[k][STEPS-2:0], 1'b1};
            end else begin
                rem_next[k] = trial[k][DB-1:0];
                nq_next[k]  = {nq_reg[k][STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= STEPS; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < STEPS; k++) v_reg[k+1] <= v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {1'b0, num[pts_pkg::NUM_BITS-1:STEPS]};
            nq_reg[0]  <= num[STEPS-1:0];
            tag_reg[0] <= in_tag;
            for (int k = 0; k < STEPS; k++) begin
                rem_reg[k+1] <= rem_next[k];
                nq_reg[k+1]  <= nq_next[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign quo       = nq_reg[STEPS];
    assign rem_nz    = (rem_reg[STEPS] != '0);
    assign out_tag   = tag_reg[STEPS];

endmodule
